FILE: rtl/max_priority_table_core_defines.svh
// Assertion macros used by the priority table core.
`ifndef MAX_PRIORITY_TABLE_CORE_DEFINES_SVH
`define MAX_PRIORITY_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MPT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("max_priority_table: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("max_priority_table: next-cycle check failed");

`endif

FILE: rtl/mpt_pkg.sv
// Types and codes shared by the priority table modules.
package mpt_pkg;

  // Stored entry: priority in the high byte, tag in the low byte.
  typedef logic [15:0] entry_t;
  typedef logic [1:0]  status_t;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef struct packed {
    entry_t     word;
    logic [7:0] occupancy;
    status_t    status;
  } result_t;

endpackage

FILE: rtl/max_priority_table_core.sv
// An insert goes from acceptance to the result state; the next item is taken after that.
// An extract on a non-empty table makes one memory read per stored entry through the
// single read port, then passes through the result state.
// An extract on an empty table goes straight to the result state, like an insert.
// Reset clears the item count and the handshake state; memory contents are not cleared.
`include "max_priority_table_core_defines.svh"

module max_priority_table_core
  import mpt_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       cmd,
  input  logic [7:0] priority_req,
  input  logic [7:0] tag,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] out_priority,
  output logic [7:0] out_tag,
  output logic [7:0] occupancy,
  output logic [1:0] status
);

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  entry_t            mem_rdata;
  logic              res_valid;
  logic              res_free;
  result_t           res;
  result_t           rsp;

  mpt_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mpt_ctrl #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (ADDR_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .cmd          (cmd),
    .priority_req (priority_req),
    .tag          (tag),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .res_valid    (res_valid),
    .res_free     (res_free),
    .res          (res)
  );

  // Output register: a waiting item does not keep the sequencer from taking a request.
  assign res_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_free) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      rsp <= res;
    end
  end

  assign out_priority = rsp.word[15:8];
  assign out_tag      = rsp.word[7:0];
  assign occupancy    = rsp.occupancy;
  assign status       = rsp.status;

  `MPT_ASSERT_NOW(a_empty_result_zero, clk, rst, rsp_valid && (status == ST_EMPTY), (occupancy == 8'd0) && (out_priority == 8'd0) && (out_tag == 8'd0))
  `MPT_ASSERT_NOW(a_full_result_zero, clk, rst, rsp_valid && (status == ST_FULL), (out_priority == 8'd0) && (out_tag == 8'd0))
  `MPT_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)
  `MPT_ASSERT_NOW(a_no_result_mem_write, clk, rst, res_valid, !mem_we && !mem_re)

endmodule

FILE: rtl/mpt_store.sv
// Entry memory: one write port, one read port with registered read data.
module mpt_store
  import mpt_pkg::*;
#(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/mpt_ctrl.sv
// Sequencer: appends inserts, scans the memory for the greatest entry on extract.
module mpt_ctrl
  import mpt_pkg::*;
#(
  parameter int CAPACITY = 128,
  parameter int ADDR_W   = 7,
  parameter int CNT_W    = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic              cmd,
  input  logic [7:0]        priority_req,
  input  logic [7:0]        tag,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output entry_t            mem_wdata,
  output logic              mem_re,
  output logic [ADDR_W-1:0] mem_raddr,
  input  entry_t            mem_rdata,
  output logic              res_valid,
  input  logic              res_free,
  output result_t           res
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0]        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] scan_addr, scan_addr_next;
  logic [ADDR_W-1:0] best_idx, best_idx_next;
  entry_t            best, best_next;
  result_t           res_next;

  logic              accept;
  logic              take;
  logic              last;
  entry_t            cur_best;
  logic [ADDR_W-1:0] cur_idx;
  logic [CNT_W-1:0]  count_dec;
  logic [CNT_W-1:0]  count_inc;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign res_valid = (state == S_RESULT);
  assign count_dec = count - CNT_W'(1);
  assign count_inc = count + CNT_W'(1);

  // Read data arriving now belongs to scan_addr; the first one seeds the maximum.
  assign take     = (scan_addr == '0) || (mem_rdata > best);
  assign cur_best = take ? mem_rdata : best;
  assign cur_idx  = take ? scan_addr : best_idx;
  assign last     = (CNT_W'(scan_addr) == count_dec);

  always_comb begin
    state_next     = state;
    count_next     = count;
    scan_addr_next = scan_addr;
    best_idx_next  = best_idx;
    best_next      = best;
    res_next       = res;
    mem_we         = 1'b0;
    mem_waddr      = count[ADDR_W-1:0];
    mem_wdata      = {priority_req, tag};
    mem_re         = 1'b0;
    mem_raddr      = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd == CMD_INSERT) begin
            state_next = S_RESULT;
            res_next.word = '0;
            if (count == CNT_W'(CAPACITY)) begin
              res_next.occupancy = 8'(count);
              res_next.status    = ST_FULL;
            end else begin
              mem_we             = 1'b1;
              count_next         = count_inc;
              res_next.occupancy = 8'(count_inc);
              res_next.status    = ST_OK;
            end
          end else if (count == '0) begin
            state_next         = S_RESULT;
            res_next.word      = '0;
            res_next.occupancy = '0;
            res_next.status    = ST_EMPTY;
          end else begin
            mem_re         = 1'b1;
            mem_raddr      = '0;
            scan_addr_next = '0;
            state_next     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        best_next     = cur_best;
        best_idx_next = cur_idx;
        if (last) begin
          // The last stored entry fills the slot of the one removed.
          mem_we             = 1'b1;
          mem_waddr          = cur_idx;
          mem_wdata          = mem_rdata;
          count_next         = count_dec;
          res_next.word      = cur_best;
          res_next.occupancy = 8'(count_dec);
          res_next.status    = ST_OK;
          state_next         = S_RESULT;
        end else begin
          mem_re         = 1'b1;
          mem_raddr      = ADDR_W'(scan_addr + 1'b1);
          scan_addr_next = ADDR_W'(scan_addr + 1'b1);
        end
      end
      S_RESULT: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr <= scan_addr_next;
    best_idx  <= best_idx_next;
    best      <= best_next;
    res       <= res_next;
  end

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the max priority table core.
module tb;
  import mpt_pkg::*;

  localparam int CAPACITY = 128;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = CAPACITY + 16;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic cmd = CMD_INSERT;
  logic [7:0] priority_req = 8'd0;
  logic [7:0] tag = 8'd0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [7:0] out_priority;
  logic [7:0] out_tag;
  logic [7:0] occupancy;
  logic [1:0] status;

  // Shadow copy of the table contents and the expected results in flight.
  entry_t shadow_table [CAPACITY];
  int shadow_count = 0;
  result_t pending_results [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  max_priority_table_core #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .cmd(cmd),
    .priority_req(priority_req),
    .tag(tag),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .out_priority(out_priority),
    .out_tag(out_tag),
    .occupancy(occupancy),
    .status(status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Applies one operation to the shadow table and returns the result it must produce.
  function automatic result_t predict_table_op(logic op, logic [7:0] prio, logic [7:0] tg);
    result_t r;
    int best;
    r = '0;
    r.status = ST_OK;
    if (op == CMD_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        shadow_table[shadow_count] = {prio, tg};
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < shadow_count; i++) begin
        if (shadow_table[i] > shadow_table[best]) best = i;
      end
      r.word = shadow_table[best];
      shadow_count--;
      shadow_table[best] = shadow_table[shadow_count];
    end
    r.occupancy = 8'(shadow_count);
    return r;
  endfunction

  // Offers one item, with an occasional idle gap first, and waits until it is taken.
  task automatic send_op(logic op, logic [7:0] prio, logic [7:0] tg);
    if (!no_idle && $urandom_range(99) < 35) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 35);
    end
    req_valid <= 1'b1;
    cmd <= op;
    priority_req <= prio;
    tag <= tg;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_results.insert(pending_results.size(), predict_table_op(op, prio, tg));
  endtask

  task automatic send_extract();
    send_op(CMD_EXTRACT, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic test_empty_extract();
    send_op(CMD_EXTRACT, 8'd0, 8'd0);
    send_op(CMD_EXTRACT, 8'hFF, 8'hFF);
  endtask

  // Field extremes, ties on priority broken by tag, and duplicate items.
  task automatic test_field_extremes();
    send_op(CMD_INSERT, 8'h00, 8'h00);
    send_op(CMD_INSERT, 8'hFF, 8'h00);
    send_op(CMD_INSERT, 8'h00, 8'hFF);
    send_op(CMD_INSERT, 8'hFF, 8'hFF);
    send_op(CMD_INSERT, 8'h80, 8'h01);
    send_op(CMD_INSERT, 8'h01, 8'h80);
    send_op(CMD_INSERT, 8'hFF, 8'hFF);
    send_op(CMD_INSERT, 8'h55, 8'hAA);
    send_op(CMD_INSERT, 8'hAA, 8'h55);
    for (int i = 0; i < 10; i++) send_extract();
  endtask

  // Fills the table, inserts into the full table, then drains it past empty.
  task automatic test_full_table();
    for (int i = 0; i < CAPACITY; i++) begin
      if (i % 3 == 0) send_op(CMD_INSERT, 8'($urandom_range(255, 252)), 8'($urandom_range(3)));
      else send_op(CMD_INSERT, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
    send_op(CMD_INSERT, 8'hFF, 8'hFF);
    send_op(CMD_INSERT, 8'h00, 8'h00);
    send_op(CMD_INSERT, 8'($urandom_range(255)), 8'($urandom_range(255)));
    for (int i = 0; i <= CAPACITY; i++) send_extract();
  endtask

  // Random mix in phases that lean toward growing or shrinking the table, or keep it balanced.
  task automatic test_random_mix(int n_items);
    int insert_pct;
    logic [7:0] prio;
    logic [7:0] tg;
    insert_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 25;
          1: insert_pct = 50;
          default: insert_pct = 75;
        endcase
      end
      if ($urandom_range(99) < insert_pct) begin
        // Narrow ranges produce many ties on priority and on whole items.
        if ($urandom_range(2) == 0) begin
          prio = 8'($urandom_range(255, 250));
          tg = 8'($urandom_range(2));
        end else begin
          prio = 8'($urandom_range(255));
          tg = 8'($urandom_range(255));
        end
        send_op(CMD_INSERT, prio, tg);
      end else begin
        send_extract();
      end
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Result with no item outstanding: prio %0d tag %0d occ %0d status %0d",
                   out_priority, out_tag, occupancy, status);
      end else begin
        want = pending_results.pop_front();
        if (out_priority !== want.word[15:8] || out_tag !== want.word[7:0] ||
            occupancy !== want.occupancy || status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected prio %0d tag %0d occ %0d status %0d, got prio %0d tag %0d occ %0d status %0d",
                     want.word[15:8], want.word[7:0], want.occupancy, want.status,
                     out_priority, out_tag, occupancy, status);
        end
      end
    end
    rsp_stall <= !no_idle && ($urandom_range(99) < 35);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_extract();
    test_field_extremes();
    test_full_table();
    no_idle = 1'b1;
    test_random_mix(100);
    no_idle = 1'b0;
    test_random_mix(420);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
